@@ rtl/teq_pkg.sv @@
// ----------------------------------------------------------------------------
// teq_pkg: shared types and codes of the timer event queue
// Input modes, result kinds, the per-cell queue operation and the cap on
// events reported by one tick.
// ----------------------------------------------------------------------------
package teq_pkg;

	// input item modes
	localparam logic [1:0] MODE_SCHEDULE = 2'd0;
	localparam logic [1:0] MODE_TICK     = 2'd1;
	localparam logic [1:0] MODE_CLEAR    = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_FIRED     = 3'd0;
	localparam logic [2:0] KIND_NO_EVENT  = 3'd1;
	localparam logic [2:0] KIND_SCHEDULED = 3'd2;
	localparam logic [2:0] KIND_DROPPED   = 3'd3;
	localparam logic [2:0] KIND_CLEARED   = 3'd4;

	// most events reported by a single tick
	localparam int unsigned MAX_FIRED = 16;
	localparam int unsigned FIRED_W   = 5;

	// operation broadcast to every cell of the row
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP
	} queue_op_t;

endpackage

@@ rtl/teq_cell.sv @@
// ----------------------------------------------------------------------------
// teq_cell: one slot of the sorted event row
// Holds a due time and a handle. On insert it keeps its entry, takes the new
// event or takes its left neighbor's entry; on pop it takes the right one.
// ----------------------------------------------------------------------------
module teq_cell #(
	parameter int TIME_WIDTH   = 48,
	parameter int HANDLE_WIDTH = 8
) (
	input  logic                    clk,
	input  teq_pkg::queue_op_t      op,
	input  logic                    occ,
	input  logic                    prev_keep,
	input  logic [TIME_WIDTH-1:0]   new_due,
	input  logic [HANDLE_WIDTH-1:0] new_handle,
	input  logic [TIME_WIDTH-1:0]   left_due,
	input  logic [HANDLE_WIDTH-1:0] left_handle,
	input  logic [TIME_WIDTH-1:0]   right_due,
	input  logic [HANDLE_WIDTH-1:0] right_handle,
	output logic                    keep,
	output logic [TIME_WIDTH-1:0]   due,
	output logic [HANDLE_WIDTH-1:0] handle
);

	logic [TIME_WIDTH-1:0]   due_q;
	logic [HANDLE_WIDTH-1:0] handle_q;

	// equal due times stay ahead of the new event
	assign keep   = occ && (due_q <= new_due);
	assign due    = due_q;
	assign handle = handle_q;

	// slot update
	always_ff @(posedge clk) begin
		case (op)
			teq_pkg::OP_INSERT: begin
				if (!keep) begin
					if (prev_keep) begin
						due_q    <= new_due;
						handle_q <= new_handle;
					end else begin
						due_q    <= left_due;
						handle_q <= left_handle;
					end
				end
			end
			teq_pkg::OP_POP: begin
				due_q    <= right_due;
				handle_q <= right_handle;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/teq_row.sv @@
// ----------------------------------------------------------------------------
// teq_row: row of event cells kept in due-time order
// Cell 0 is the head. The fill count marks which cells hold events.
// ----------------------------------------------------------------------------
module teq_row #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int TIME_WIDTH   = 48,
	parameter int HANDLE_WIDTH = 8,
	parameter int COUNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                    clk,
	input  teq_pkg::queue_op_t      op,
	input  logic [COUNT_W-1:0]      count,
	input  logic [TIME_WIDTH-1:0]   new_due,
	input  logic [HANDLE_WIDTH-1:0] new_handle,
	output logic [TIME_WIDTH-1:0]   head_due,
	output logic [HANDLE_WIDTH-1:0] head_handle,
	output logic [TIME_WIDTH-1:0]   next_due
);

	logic [TIME_WIDTH-1:0]   due_w    [QUEUE_DEPTH];
	logic [HANDLE_WIDTH-1:0] handle_w [QUEUE_DEPTH];
	logic                    keep_w   [QUEUE_DEPTH];

	assign head_due    = due_w[0];
	assign head_handle = handle_w[0];
	assign next_due    = due_w[1];

	// cells with their neighbor links
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                    occ;
		logic                    prev_keep;
		logic [TIME_WIDTH-1:0]   left_due;
		logic [HANDLE_WIDTH-1:0] left_handle;
		logic [TIME_WIDTH-1:0]   right_due;
		logic [HANDLE_WIDTH-1:0] right_handle;

		assign occ = count > COUNT_W'(i);

		if (i == 0) begin : g_head
			assign prev_keep   = 1'b1;
			assign left_due    = new_due;
			assign left_handle = new_handle;
		end else begin : g_body
			assign prev_keep   = keep_w[i-1];
			assign left_due    = due_w[i-1];
			assign left_handle = handle_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_due    = due_w[i];
			assign right_handle = handle_w[i];
		end else begin : g_inner
			assign right_due    = due_w[i+1];
			assign right_handle = handle_w[i+1];
		end

		teq_cell #(
			.TIME_WIDTH  (TIME_WIDTH),
			.HANDLE_WIDTH(HANDLE_WIDTH)
		) u_cell (
			.clk         (clk),
			.op          (op),
			.occ         (occ),
			.prev_keep   (prev_keep),
			.new_due     (new_due),
			.new_handle  (new_handle),
			.left_due    (left_due),
			.left_handle (left_handle),
			.right_due   (right_due),
			.right_handle(right_handle),
			.keep        (keep_w[i]),
			.due         (due_w[i]),
			.handle      (handle_w[i])
		);
	end

endmodule

@@ rtl/timer_event_queue_top.sv @@
// ----------------------------------------------------------------------------
// timer_event_queue_top: timer event queue
// Sorted row of pending events, tick time base with delta and total, and a
// sequencer that reports scheduled, dropped, fired and cleared events and empty ticks.
//
//   port group   dir   fields
//   in_*         in    mode, due_time, event_handle, clock_reading
//   out_*        out   kind, fired_handle, fire_time, tick_gap,
//                      total_elapsed, last
//   cfg_*        in    cfg_data (target period)
//
// One item at a time. A tick steps through floor, current, delta and sum states,
// then reports each fired event, or one no-event result (up to 16 results).
// The tick time base runs through add, max, subtract and 64-bit add stages.
// The queue is empty after reset; no clearing pass.
// A stalled output holds the sequencer in the schedule, pop and clear states; input is taken when idle.
// ----------------------------------------------------------------------------
module timer_event_queue_top #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int HANDLE_WIDTH = 8,
	parameter int TIME_WIDTH   = 48
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              mode,
	input  logic [TIME_WIDTH-1:0]   due_time,
	input  logic [HANDLE_WIDTH-1:0] event_handle,
	input  logic [TIME_WIDTH-1:0]   clock_reading,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              kind,
	output logic [HANDLE_WIDTH-1:0] fired_handle,
	output logic [TIME_WIDTH-1:0]   fire_time,
	output logic [TIME_WIDTH-1:0]   tick_gap,
	output logic [63:0]             total_elapsed,
	output logic                    last,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [TIME_WIDTH-1:0]   cfg_data
);

	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int FW      = teq_pkg::FIRED_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCHED,
		ST_FLOOR,
		ST_CUR,
		ST_DELTA,
		ST_SUM,
		ST_POP,
		ST_CLEAR
	} state_t;

	state_t                  state_q;
	logic [TIME_WIDTH-1:0]   target_q;
	logic [TIME_WIDTH-1:0]   due_q;
	logic [HANDLE_WIDTH-1:0] handle_q;
	logic [TIME_WIDTH-1:0]   clock_q;
	logic [COUNT_W-1:0]      count_q;
	logic [TIME_WIDTH-1:0]   last_tick_q;
	logic [TIME_WIDTH-1:0]   last_delta_q;
	logic [63:0]             elapsed_q;
	logic [TIME_WIDTH-1:0]   floor_q;
	logic [TIME_WIDTH-1:0]   cur_q;
	logic [FW-1:0]           popped_q;

	logic                    out_valid_q;
	logic [2:0]              kind_q;
	logic [HANDLE_WIDTH-1:0] fired_handle_q;
	logic [TIME_WIDTH-1:0]   fire_time_q;
	logic [TIME_WIDTH-1:0]   tick_gap_q;
	logic [63:0]             total_elapsed_q;
	logic                    last_q;

	logic [TIME_WIDTH-1:0]   head_due;
	logic [HANDLE_WIDTH-1:0] head_handle;
	logic [TIME_WIDTH-1:0]   next_due;
	logic [TIME_WIDTH:0]     floor_sum;

	logic                    out_free;
	logic                    due_past;
	logic                    q_full;
	logic                    head_exp;
	logic                    next_exp;
	teq_pkg::queue_op_t      op;
	logic                    emit_en;
	logic [2:0]              emit_kind;
	logic [HANDLE_WIDTH-1:0] emit_handle;
	logic [TIME_WIDTH-1:0]   emit_time;
	logic                    emit_last;
	logic                    emit_clear;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign fired_handle  = fired_handle_q;
	assign fire_time     = fire_time_q;
	assign tick_gap      = tick_gap_q;
	assign total_elapsed = total_elapsed_q;
	assign last          = last_q;

	// event row
	teq_row #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_WIDTH  (TIME_WIDTH),
		.HANDLE_WIDTH(HANDLE_WIDTH),
		.COUNT_W     (COUNT_W)
	) u_row (
		.clk        (clk),
		.op         (op),
		.count      (count_q),
		.new_due    (due_q),
		.new_handle (handle_q),
		.head_due   (head_due),
		.head_handle(head_handle),
		.next_due   (next_due)
	);

	// saturating floor of the next tick
	assign floor_sum = {1'b0, last_tick_q} + {1'b0, target_q};

	assign out_free = !out_valid_q || out_ready;
	assign due_past = due_q <= last_tick_q;
	assign q_full   = count_q == COUNT_W'(QUEUE_DEPTH);
	assign head_exp = (count_q != '0) && (popped_q < FW'(teq_pkg::MAX_FIRED))
		&& (head_due <= cur_q);
	assign next_exp = (count_q > COUNT_W'(1)) && (popped_q < FW'(teq_pkg::MAX_FIRED - 1))
		&& (next_due <= cur_q);

	// result selection and row operation
	always_comb begin
		emit_en     = 1'b0;
		emit_kind   = teq_pkg::KIND_FIRED;
		emit_handle = '0;
		emit_time   = '0;
		emit_last   = 1'b1;
		emit_clear  = 1'b0;
		op          = teq_pkg::OP_HOLD;
		case (state_q)
			ST_SCHED: begin
				if (out_free) begin
					emit_en     = 1'b1;
					emit_handle = handle_q;
					if (due_past) begin
						emit_kind = teq_pkg::KIND_FIRED;
						emit_time = last_tick_q;
					end else if (q_full) begin
						emit_kind = teq_pkg::KIND_DROPPED;
					end else begin
						emit_kind = teq_pkg::KIND_SCHEDULED;
						op        = teq_pkg::OP_INSERT;
					end
				end
			end
			ST_POP: begin
				if (out_free) begin
					emit_en   = 1'b1;
					emit_time = cur_q;
					if (head_exp) begin
						emit_kind   = teq_pkg::KIND_FIRED;
						emit_handle = head_handle;
						emit_last   = !next_exp;
						op          = teq_pkg::OP_POP;
					end else begin
						emit_kind = teq_pkg::KIND_NO_EVENT;
					end
				end
			end
			ST_CLEAR: begin
				if (out_free) begin
					emit_en    = 1'b1;
					emit_kind  = teq_pkg::KIND_CLEARED;
					emit_clear = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// sequencer, time base and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			target_q     <= '0;
			count_q      <= '0;
			last_tick_q  <= '0;
			last_delta_q <= '0;
			elapsed_q    <= '0;
			popped_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				target_q <= cfg_data;
			end

			// output register
			if (emit_en) begin
				out_valid_q     <= 1'b1;
				kind_q          <= emit_kind;
				fired_handle_q  <= emit_handle;
				fire_time_q     <= emit_time;
				tick_gap_q      <= emit_clear ? '0 : last_delta_q;
				total_elapsed_q <= emit_clear ? '0 : elapsed_q;
				last_q          <= emit_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// fill count follows the row operation
			case (op)
				teq_pkg::OP_INSERT: count_q <= count_q + COUNT_W'(1);
				teq_pkg::OP_POP:    count_q <= count_q - COUNT_W'(1);
				default: ;
			endcase

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						due_q    <= due_time;
						handle_q <= event_handle;
						clock_q  <= clock_reading;
						case (mode)
							teq_pkg::MODE_SCHEDULE: state_q <= ST_SCHED;
							teq_pkg::MODE_TICK:     state_q <= ST_FLOOR;
							teq_pkg::MODE_CLEAR:    state_q <= ST_CLEAR;
							default:                state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCHED: begin
					if (emit_en) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLOOR: begin
					floor_q <= floor_sum[TIME_WIDTH] ? '1 : floor_sum[TIME_WIDTH-1:0];
					state_q <= ST_CUR;
				end
				ST_CUR: begin
					cur_q   <= (clock_q < floor_q) ? floor_q : clock_q;
					state_q <= ST_DELTA;
				end
				ST_DELTA: begin
					last_delta_q <= cur_q - last_tick_q;
					last_tick_q  <= cur_q;
					state_q      <= ST_SUM;
				end
				ST_SUM: begin
					elapsed_q <= elapsed_q + 64'(last_delta_q);
					popped_q  <= '0;
					state_q   <= ST_POP;
				end
				ST_POP: begin
					if (emit_en) begin
						popped_q <= popped_q + FW'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CLEAR: begin
					if (emit_en) begin
						count_q      <= '0;
						last_delta_q <= '0;
						elapsed_q    <= '0;
						last_tick_q  <= clock_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// fill count never passes the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(QUEUE_DEPTH))
		else $error("event count beyond queue depth");

	// insert only into a row with a free slot
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(op == teq_pkg::OP_INSERT) |-> !q_full)
		else $error("insert into full queue");

	// the new tick never falls behind the previous one
	a_tick_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DELTA) |-> (cur_q >= last_tick_q))
		else $error("tick time moved backward");

	// a tick reports no more than the cap of fired events
	a_pop_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(op == teq_pkg::OP_POP) |-> (popped_q < FW'(teq_pkg::MAX_FIRED)))
		else $error("too many events fired on one tick");

endmodule

@@ tb/tb_timer_event_queue_top.sv @@
// ----------------------------------------------------------------------------
// tb_timer_event_queue_top: self-checking bench for the timer event queue
// Drives schedule, tick, clear and unused-mode items through the input
// channel and predicts every result with an in-bench model of the sorted
// queue and the tick time base. A checker compares each result with the
// oldest prediction. The period register is changed only between drained
// phases. The sender runs in bursts and the receiver stalls on shifting
// patterns, with one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_timer_event_queue_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH  = 16;
	localparam int HANDLE_WIDTH = 8;
	localparam int TIME_WIDTH   = 48;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

	localparam int DRAIN_CYCLES = 32;
	localparam int HOLD_CYCLES  = 300;
	localparam longint CYCLE_LIMIT = 600000;

	typedef struct {
		logic [2:0]              kind;
		logic [HANDLE_WIDTH-1:0] handle;
		logic [TIME_WIDTH-1:0]   fire_time;
		logic [TIME_WIDTH-1:0]   delta;
		logic [63:0]             total;
		logic                    last;
	} teq_result_t;

	typedef enum int {
		READY_ALWAYS,
		READY_HALF,
		READY_MOSTLY,
		READY_EVERY_THIRD
	} stall_pattern_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              mode;
	logic [TIME_WIDTH-1:0]   due_time;
	logic [HANDLE_WIDTH-1:0] event_handle;
	logic [TIME_WIDTH-1:0]   clock_reading;
	logic                    out_valid;
	logic                    out_ready;
	logic [2:0]              kind;
	logic [HANDLE_WIDTH-1:0] fired_handle;
	logic [TIME_WIDTH-1:0]   fire_time;
	logic [TIME_WIDTH-1:0]   tick_gap;
	logic [63:0]             total_elapsed;
	logic                    last;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [TIME_WIDTH-1:0]   cfg_data;

	// predicted block state
	logic [TIME_WIDTH-1:0]   pend_due [QUEUE_DEPTH];
	logic [HANDLE_WIDTH-1:0] pend_handle [QUEUE_DEPTH];
	int                      pend_count;
	logic [TIME_WIDTH-1:0]   tick_now;
	logic [TIME_WIDTH-1:0]   tick_delta;
	logic [63:0]             elapsed_total;
	logic [TIME_WIDTH-1:0]   period_cfg;

	teq_result_t expected_results[$];
	teq_result_t want;
	int unsigned mismatch_count;
	longint      cycle_count;

	// sender pacing
	int burst_left;
	bit sender_steady;

	// receiver pacing
	bit             hold_request;
	int             hold_left;
	stall_pattern_t ready_pattern;
	int             pattern_left;
	int unsigned    ready_phase;

	timer_event_queue_top #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH),
		.TIME_WIDTH   (TIME_WIDTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.due_time      (due_time),
		.event_handle  (event_handle),
		.clock_reading (clock_reading),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.fired_handle  (fired_handle),
		.fire_time     (fire_time),
		.tick_gap      (tick_gap),
		.total_elapsed (total_elapsed),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_timer_event_queue_top: FAIL");
			$finish;
		end
	end

	// queue one expected result, tagged with the current delta and total
	function automatic void push_result(input logic [2:0] k, input logic [HANDLE_WIDTH-1:0] h,
			input logic [TIME_WIDTH-1:0] when, input logic is_last);
		teq_result_t r;
		r.kind      = k;
		r.handle    = h;
		r.fire_time = when;
		r.delta     = tick_delta;
		r.total     = elapsed_total;
		r.last      = is_last;
		expected_results.insert(expected_results.size(), r);
	endfunction

	// advance the predicted state by one accepted item
	function automatic void predict_item(input logic [1:0] m, input logic [TIME_WIDTH-1:0] due,
			input logic [HANDLE_WIDTH-1:0] h, input logic [TIME_WIDTH-1:0] rd);
		int pos;
		int nfire;
		logic [TIME_WIDTH-1:0] prev;
		logic [TIME_WIDTH-1:0] floor_t;
		logic [TIME_WIDTH-1:0] cur;
		case (m)
			teq_pkg::MODE_SCHEDULE: begin
				if (due <= tick_now) begin
					push_result(teq_pkg::KIND_FIRED, h, tick_now, 1'b1);
				end else if (pend_count >= QUEUE_DEPTH) begin
					push_result(teq_pkg::KIND_DROPPED, h, '0, 1'b1);
				end else begin
					// insert after every entry with due time <= new one
					pos = 0;
					while (pos < pend_count && pend_due[pos] <= due)
						pos++;
					for (int i = pend_count; i > pos; i--) begin
						pend_due[i]    = pend_due[i-1];
						pend_handle[i] = pend_handle[i-1];
					end
					pend_due[pos]    = due;
					pend_handle[pos] = h;
					pend_count++;
					push_result(teq_pkg::KIND_SCHEDULED, h, '0, 1'b1);
				end
			end
			teq_pkg::MODE_TICK: begin
				prev    = tick_now;
				floor_t = (period_cfg > TIME_MAX - prev) ? TIME_MAX : prev + period_cfg;
				cur     = (rd < floor_t) ? floor_t : rd;
				tick_now      = cur;
				tick_delta    = cur - prev;
				elapsed_total = elapsed_total + 64'(tick_delta);
				nfire = 0;
				while (nfire < pend_count && nfire < int'(teq_pkg::MAX_FIRED)
						&& pend_due[nfire] <= cur)
					nfire++;
				if (nfire == 0) begin
					push_result(teq_pkg::KIND_NO_EVENT, '0, cur, 1'b1);
				end else begin
					for (int i = 0; i < nfire; i++)
						push_result(teq_pkg::KIND_FIRED, pend_handle[i], cur, i == nfire - 1);
					for (int i = nfire; i < pend_count; i++) begin
						pend_due[i-nfire]    = pend_due[i];
						pend_handle[i-nfire] = pend_handle[i];
					end
					pend_count -= nfire;
				end
			end
			teq_pkg::MODE_CLEAR: begin
				pend_count    = 0;
				tick_delta    = '0;
				elapsed_total = '0;
				tick_now      = rd;
				push_result(teq_pkg::KIND_CLEARED, '0, '0, 1'b1);
			end
			default: ;
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: kind=%0d handle=%0d fire=%0d last=%0b",
						kind, fired_handle, fire_time, last);
			end else begin
				want = expected_results.pop_front();
				if (kind !== want.kind || fired_handle !== want.handle ||
						fire_time !== want.fire_time || tick_gap !== want.delta ||
						total_elapsed !== want.total || last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch exp: kind=%0d handle=%0d fire=%0d delta=%0d total=%0d last=%0b",
							want.kind, want.handle, want.fire_time, want.delta, want.total,
							want.last);
						$display("         got: kind=%0d handle=%0d fire=%0d delta=%0d total=%0d last=%0b",
							kind, fired_handle, fire_time, tick_gap, total_elapsed, last);
					end
				end
			end
		end
	end

	// receiver: shifting stall patterns, plus a long hold-off on request
	initial begin
		out_ready <= 1'b0;
		hold_left = 0;
		pattern_left = 0;
		ready_phase = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					ready_pattern = stall_pattern_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(16, 96);
				end
				pattern_left--;
				ready_phase++;
				case (ready_pattern)
					READY_ALWAYS:      out_ready <= 1'b1;
					READY_HALF:        out_ready <= 1'($urandom_range(0, 1));
					READY_MOSTLY:      out_ready <= ($urandom_range(0, 9) != 0);
					READY_EVERY_THIRD: out_ready <= (ready_phase % 3 == 0);
					default:           out_ready <= 1'b1;
				endcase
			end
		end
	end

	// offer one item, wait for it to be taken, then predict it
	task automatic send_item(input logic [1:0] m, input logic [TIME_WIDTH-1:0] due,
			input logic [HANDLE_WIDTH-1:0] h, input logic [TIME_WIDTH-1:0] rd);
		int gap;
		if (burst_left == 0) begin
			gap = sender_steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid      <= 1'b1;
		mode          <= m;
		due_time      <= due;
		event_handle  <= h;
		clock_reading <= rd;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_item(m, due, h, rd);
	endtask

	// stop offering and wait until every predicted result has arrived
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write the tick period while the block is idle
	task automatic set_period(input logic [TIME_WIDTH-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		period_cfg = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [TIME_WIDTH-1:0] rand_time();
		return TIME_WIDTH'({$urandom, $urandom});
	endfunction

	// one item, mostly well formed around the current tick time
	task automatic send_random_item(output bit counted);
		int pick;
		logic [TIME_WIDTH-1:0] due;
		logic [TIME_WIDTH-1:0] rd;
		logic [HANDLE_WIDTH-1:0] h;
		logic [1:0] m;
		h = HANDLE_WIDTH'($urandom);
		pick = $urandom_range(0, 99);
		due = rand_time();
		rd = rand_time();
		counted = 1'b1;
		if (pick < 50) begin
			m = teq_pkg::MODE_SCHEDULE;
			due = tick_now + TIME_WIDTH'($urandom_range(0, 1) ? 10 * $urandom_range(1, 30)
				: $urandom_range(1, 300));
		end else if (pick < 56) begin
			m = teq_pkg::MODE_SCHEDULE;
			due = tick_now - TIME_WIDTH'($urandom_range(0, 50));
		end else if (pick < 82) begin
			m = teq_pkg::MODE_TICK;
			rd = tick_now + TIME_WIDTH'($urandom_range(0, 400));
		end else if (pick < 86) begin
			m = teq_pkg::MODE_TICK;
			rd = tick_now - TIME_WIDTH'($urandom_range(1, 100));
		end else if (pick < 89) begin
			m = teq_pkg::MODE_CLEAR;
			if ($urandom_range(0, 1))
				rd = TIME_WIDTH'($urandom_range(0, 1000));
		end else if (pick < 92) begin
			m = MODE_UNUSED;
		end else begin
			m = 2'($urandom_range(0, 3));
		end
		if (m == MODE_UNUSED)
			counted = 1'b0;
		send_item(m, due, h, rd);
	endtask

	// a run of schedules without ticks, enough to overflow the queue
	task automatic send_fill_run(output int sent);
		sent = QUEUE_DEPTH + 2;
		for (int i = 0; i < sent; i++)
			send_item(teq_pkg::MODE_SCHEDULE, tick_now + TIME_WIDTH'($urandom_range(1, 60)),
				HANDLE_WIDTH'($urandom), rand_time());
	endtask

	// reset values: zero time base, zero period, unused mode
	task automatic test_after_reset();
		send_item(teq_pkg::MODE_TICK, rand_time(), HANDLE_WIDTH'($urandom), '0);
		send_item(teq_pkg::MODE_SCHEDULE, '0, 8'hFF, rand_time());
		send_item(MODE_UNUSED, TIME_MAX, 8'hA5, TIME_MAX);
		send_item(teq_pkg::MODE_TICK, '0, '0, 48'd100);
		wait_drained();
	endtask

	// full queue, drop, equal due times in order, one tick firing all
	task automatic test_queue_full();
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_item(teq_pkg::MODE_SCHEDULE,
				(i == 7) ? TIME_MAX : 48'(150 + ((i * 7) % 4) * 50),
				(i == QUEUE_DEPTH - 1) ? 8'hFF : HANDLE_WIDTH'(i * 16), '0);
		send_item(teq_pkg::MODE_SCHEDULE, 48'd500, 8'h5A, '0);
		send_item(teq_pkg::MODE_TICK, '0, '0, TIME_MAX);
		send_item(teq_pkg::MODE_SCHEDULE, TIME_MAX, 8'h3C, '0);
		wait_drained();
	endtask

	// tick floor: saturated sum and a clock reading below the floor
	task automatic test_tick_floor();
		set_period(TIME_MAX);
		send_item(teq_pkg::MODE_CLEAR, '0, '0, TIME_MAX - 48'd5);
		send_item(teq_pkg::MODE_TICK, '0, '0, '0);
		set_period(48'd10);
		send_item(teq_pkg::MODE_CLEAR, '0, '0, 48'd1000);
		send_item(teq_pkg::MODE_SCHEDULE, 48'd1005, 8'h81, '0);
		send_item(teq_pkg::MODE_TICK, '0, '0, 48'd3);
		wait_drained();
	endtask

	// random traffic under one period setting
	task automatic test_random(input int n, input logic [TIME_WIDTH-1:0] period);
		int sent;
		int run;
		bit counted;
		set_period(period);
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 39) == 0) begin
				send_fill_run(run);
				sent += run;
			end else begin
				send_random_item(counted);
				if (counted)
					sent++;
			end
		end
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_backpressure(input int n);
		int sent;
		bit counted;
		set_period(48'd5);
		sender_steady = 1'b1;
		hold_request = 1'b1;
		sent = 0;
		while (sent < n) begin
			send_random_item(counted);
			if (counted)
				sent++;
		end
		sender_steady = 1'b0;
		wait_drained();
	endtask

	// main sequence
	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		mode          <= teq_pkg::MODE_SCHEDULE;
		due_time      <= '0;
		event_handle  <= '0;
		clock_reading <= '0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		hold_request  = 1'b0;
		sender_steady = 1'b0;
		burst_left    = 0;
		mismatch_count = 0;
		cycle_count   = 0;
		pend_count    = 0;
		tick_now      = '0;
		tick_delta    = '0;
		elapsed_total = '0;
		period_cfg    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_queue_full();
		test_tick_floor();
		test_random(50, '0);
		test_random(50, 48'($urandom_range(1, 40)));
		test_backpressure(25);
		test_random(40, rand_time());
		test_random(25, TIME_MAX);
		wait_drained();

		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("tb_timer_event_queue_top: PASS");
		end else begin
			$display("tb_timer_event_queue_top: FAIL");
		end
		$finish;
	end

endmodule

@@ timer_event_queue_top.f @@
rtl/teq_pkg.sv
rtl/teq_cell.sv
rtl/teq_row.sv
rtl/timer_event_queue_top.sv
tb/tb_timer_event_queue_top.sv
